@@ rtl/rgbnv12_pkg.sv @@
// ----------------------------------------------------------------------------
// rgbnv12_pkg
// Shared types and constants for the BT.601 RGB to NV12 converter.
// ----------------------------------------------------------------------------
package rgbnv12_pkg;

   localparam int MaxWidth   = 4096;
   localparam int MaxHeight  = 4096;
   localparam int LineDepth  = MaxWidth / 2;
   localparam int LineAddrW  = $clog2(LineDepth);
   localparam int ColW       = $clog2(MaxWidth);
   localparam int RowW       = $clog2(MaxHeight);
   localparam int SizeW      = 13;
   localparam int CsrIndexW  = 2;
   localparam int CompW      = 8;
   localparam int PairW      = CompW + 1;
   localparam int PairSumW   = 3 * PairW;

   localparam logic [SizeW-1:0] MAX_WIDTH_VAL  = SizeW'(MaxWidth);
   localparam logic [SizeW-1:0] MAX_HEIGHT_VAL = SizeW'(MaxHeight);

   // Register indexes of the configuration port.
   localparam logic [CsrIndexW-1:0] REG_FRAME_WIDTH  = 2'd0;
   localparam logic [CsrIndexW-1:0] REG_FRAME_HEIGHT = 2'd1;

   // Luma coefficients.
   localparam logic [16:0] LUMA_R   = 17'd66;
   localparam logic [16:0] LUMA_G   = 17'd129;
   localparam logic [16:0] LUMA_B   = 17'd25;
   localparam logic [16:0] ROUND    = 17'd128;
   localparam logic [7:0]  LUMA_OFS = 8'd16;

   // Chroma coefficients.
   localparam logic signed [17:0] CB_R = -18'sd38;
   localparam logic signed [17:0] CB_G = -18'sd74;
   localparam logic signed [17:0] CB_B = 18'sd112;
   localparam logic signed [17:0] CR_R = 18'sd112;
   localparam logic signed [17:0] CR_G = -18'sd94;
   localparam logic signed [17:0] CR_B = -18'sd18;
   localparam logic signed [17:0] CHROMA_ROUND = 18'sd128;
   localparam logic signed [9:0]  CHROMA_OFS   = 10'sd128;

   typedef struct packed {
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } req_word_type;

   typedef struct packed {
      logic [7:0] luma;
      logic       chroma_valid;
      logic [7:0] chroma_blue;
      logic [7:0] chroma_red;
      logic       frame_last;
      logic       bad_size;
   } rsp_word_type;

   // Write side of the line store.
   typedef struct packed {
      logic                 en;
      logic [LineAddrW-1:0] addr;
      logic [PairSumW-1:0]  data;
   } line_wr_type;

endpackage

@@ rtl/rgbnv12_line_mem.sv @@
// ----------------------------------------------------------------------------
// rgbnv12_line_mem
// Line store of horizontal pair sums, one write and one read port, with the
// read data registered.
// ----------------------------------------------------------------------------
module rgbnv12_line_mem (
   input  logic                                 clock,
   input  rgbnv12_pkg::line_wr_type             wr,
   input  logic                                 rd_en,
   input  logic [rgbnv12_pkg::LineAddrW-1:0]    rd_addr,
   output logic [rgbnv12_pkg::PairSumW-1:0]     rd_data
);
   import rgbnv12_pkg::*;

   logic [PairSumW-1:0] mem_ff [LineDepth];
   logic [PairSumW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= wr.data;
      end
   end

   // The read word is only refreshed when a new read is issued, so it holds
   // while the stage that consumes it is stalled.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/rgb_to_nv12_bt601_core.sv @@
// ----------------------------------------------------------------------------
// rgb_to_nv12_bt601_core
// BT.601 limited-range RGB to NV12 converter: luma per pixel, Cb/Cr per
// 2x2 block from floor-averaged RGB, using a line store of pair sums.
//
//   Channel   Direction  Handshake              Word
//   req_      in         req_valid / req_stall  blue, green, red
//   rsp_      out        rsp_valid / rsp_stall  luma, chroma, frame_last, bad_size
//   csr_      in         csr_write_en           csr_index, csr_wdata
//
// One pixel is taken per clock while req_stall is low; a result passes stage 1,
// stage 2 and the output register. At accept the line store is written on odd
// columns of even rows and read on odd columns of odd rows. Reset is synchronous
// and clears the counters and the valid flags; the line store is not cleared.
// A stall on rsp_ backs up through the three stages and raises req_stall when full.
// ----------------------------------------------------------------------------
module rgb_to_nv12_bt601_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  rgbnv12_pkg::req_word_type           req_word,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output rgbnv12_pkg::rsp_word_type           rsp_word,
   input  logic                                csr_write_en,
   input  logic [rgbnv12_pkg::CsrIndexW-1:0]   csr_index,
   input  logic [rgbnv12_pkg::SizeW-1:0]       csr_wdata
);
   import rgbnv12_pkg::*;

   // Configuration and position state.
   logic [SizeW-1:0] width_ff, width_in;
   logic [SizeW-1:0] height_ff, height_in;
   logic [ColW-1:0]  col_ff, col_in;
   logic [RowW-1:0]  row_ff, row_in;
   logic [23:0]      left_ff, left_in;

   // Stage 1: pixel, pair sum and flags.
   logic                s1_valid_ff, s1_valid_in;
   req_word_type        s1_pix_ff;
   logic [PairSumW-1:0] s1_sum_ff;
   logic                s1_chroma_ff;
   logic                s1_last_ff;
   logic                s1_bad_ff;

   // Stage 2: luma and block averages.
   logic             s2_valid_ff, s2_valid_in;
   logic [7:0]       s2_luma_ff;
   logic [7:0]       s2_avg_b_ff, s2_avg_g_ff, s2_avg_r_ff;
   logic             s2_chroma_ff;
   logic             s2_last_ff;
   logic             s2_bad_ff;

   // Output register.
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_word_type     rsp_word_ff;

   logic             out_free, s2_free, s1_free, accept;
   logic             bad;
   logic             col_odd, row_odd;
   logic             wrap_col, wrap_row;
   logic [PairW-1:0] pair_b, pair_g, pair_r;
   logic [PairSumW-1:0] pair_sum;
   line_wr_type      line_wr;
   logic             line_rd_en;
   logic [PairSumW-1:0] line_rd_data;

   logic [16:0]      luma_acc;
   logic [7:0]       luma_val;
   logic [PairW:0]   sum4_b, sum4_g, sum4_r;
   logic signed [17:0] cb_acc, cr_acc;
   logic signed [9:0]  cb_sh, cr_sh;
   logic [7:0]       cb_val, cr_val;

   function automatic logic [7:0] clip8(input logic signed [9:0] v);
      logic [7:0] res;
      if (v < 10'sd0) begin
         res = 8'd0;
      end else if (v > 10'sd255) begin
         res = 8'd255;
      end else begin
         res = v[7:0];
      end
      return res;
   endfunction

   // ------------------------------------------------------------------------
   // Flow control.
   // ------------------------------------------------------------------------
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s2_free   = !s2_valid_ff || out_free;
   assign s1_free   = !s1_valid_ff || s2_free;
   assign req_stall = !s1_free;
   assign accept    = req_valid && s1_free;

   assign s1_valid_in  = s1_free  ? accept      : 1'b1;
   assign s2_valid_in  = s2_free  ? s1_valid_ff : 1'b1;
   assign rsp_valid_in = out_free ? s2_valid_ff : 1'b1;

   // ------------------------------------------------------------------------
   // Position tracking and the line store accesses at accept.
   // ------------------------------------------------------------------------
   assign bad = (width_ff == '0) || (height_ff == '0) || width_ff[0] || height_ff[0]
                || (width_ff > MAX_WIDTH_VAL) || (height_ff > MAX_HEIGHT_VAL);

   assign col_odd  = col_ff[0];
   assign row_odd  = row_ff[0];
   assign wrap_col = ({1'b0, col_ff} + 13'd1) >= width_ff;
   assign wrap_row = ({1'b0, row_ff} + 13'd1) >= height_ff;

   assign pair_b   = {1'b0, req_word.blue}  + {1'b0, left_ff[7:0]};
   assign pair_g   = {1'b0, req_word.green} + {1'b0, left_ff[15:8]};
   assign pair_r   = {1'b0, req_word.red}   + {1'b0, left_ff[23:16]};
   assign pair_sum = {pair_r, pair_g, pair_b};

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      left_in   = left_ff;
      if (csr_write_en && (csr_index == REG_FRAME_WIDTH || csr_index == REG_FRAME_HEIGHT))
      begin
         if (csr_index == REG_FRAME_WIDTH) begin
            width_in = csr_wdata;
         end else begin
            height_in = csr_wdata;
         end
         col_in = '0;
         row_in = '0;
      end else if (accept && !bad) begin
         if (!col_odd) begin
            left_in = {req_word.red, req_word.green, req_word.blue};
         end
         if (wrap_col) begin
            col_in = '0;
            row_in = wrap_row ? '0 : row_ff + RowW'(1);
         end else begin
            col_in = col_ff + ColW'(1);
         end
      end
   end

   assign line_wr.en   = accept && !bad && col_odd && !row_odd;
   assign line_wr.addr = col_ff[ColW-1:1];
   assign line_wr.data = pair_sum;
   assign line_rd_en   = accept && !bad && col_odd && row_odd;

   rgbnv12_line_mem u_line_mem (
      .clock   (clock),
      .wr      (line_wr),
      .rd_en   (line_rd_en),
      .rd_addr (col_ff[ColW-1:1]),
      .rd_data (line_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= '0;
         height_ff <= '0;
         col_ff    <= '0;
         row_ff    <= '0;
         left_ff   <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         left_ff   <= left_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 1 payload.
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pix_ff    <= req_word;
         s1_sum_ff    <= pair_sum;
         s1_chroma_ff <= !bad && col_odd && row_odd;
         s1_last_ff   <= !bad && ({1'b0, row_ff} + 13'd1 == height_ff)
                         && ({1'b0, col_ff} + 13'd1 == width_ff);
         s1_bad_ff    <= bad;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 2: luma and the floor average of the 2x2 block.
   // ------------------------------------------------------------------------
   assign luma_acc = LUMA_R * 17'(s1_pix_ff.red) + LUMA_G * 17'(s1_pix_ff.green)
                     + LUMA_B * 17'(s1_pix_ff.blue) + ROUND;
   assign luma_val = luma_acc[15:8] + LUMA_OFS;

   assign sum4_b = {1'b0, s1_sum_ff[PairW-1:0]}         + {1'b0, line_rd_data[PairW-1:0]};
   assign sum4_g = {1'b0, s1_sum_ff[2*PairW-1:PairW]}   + {1'b0, line_rd_data[2*PairW-1:PairW]};
   assign sum4_r = {1'b0, s1_sum_ff[3*PairW-1:2*PairW]} + {1'b0, line_rd_data[3*PairW-1:2*PairW]};

   always_ff @(posedge clock) begin
      if (s2_free && s1_valid_ff) begin
         s2_luma_ff   <= s1_bad_ff ? 8'd0 : luma_val;
         s2_avg_b_ff  <= sum4_b[PairW:2];
         s2_avg_g_ff  <= sum4_g[PairW:2];
         s2_avg_r_ff  <= sum4_r[PairW:2];
         s2_chroma_ff <= s1_chroma_ff;
         s2_last_ff   <= s1_last_ff;
         s2_bad_ff    <= s1_bad_ff;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 3: chroma into the output register.
   // ------------------------------------------------------------------------
   assign cb_acc = CB_R * $signed({10'd0, s2_avg_r_ff}) + CB_G * $signed({10'd0, s2_avg_g_ff})
                   + CB_B * $signed({10'd0, s2_avg_b_ff}) + CHROMA_ROUND;
   assign cr_acc = CR_R * $signed({10'd0, s2_avg_r_ff}) + CR_G * $signed({10'd0, s2_avg_g_ff})
                   + CR_B * $signed({10'd0, s2_avg_b_ff}) + CHROMA_ROUND;
   assign cb_sh  = 10'(cb_acc >>> 8) + CHROMA_OFS;
   assign cr_sh  = 10'(cr_acc >>> 8) + CHROMA_OFS;
   assign cb_val = clip8(cb_sh);
   assign cr_val = clip8(cr_sh);

   always_ff @(posedge clock) begin
      if (out_free && s2_valid_ff) begin
         rsp_word_ff.luma         <= s2_luma_ff;
         rsp_word_ff.chroma_valid <= s2_chroma_ff;
         rsp_word_ff.chroma_blue  <= s2_chroma_ff ? cb_val : 8'd0;
         rsp_word_ff.chroma_red   <= s2_chroma_ff ? cr_val : 8'd0;
         rsp_word_ff.frame_last   <= s2_last_ff;
         rsp_word_ff.bad_size     <= s2_bad_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // ------------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------------
   a_no_rw_same_cycle: assert property (@(posedge clock) disable iff (reset)
      !(line_wr.en && line_rd_en))
      else $error("line store written and read by the same word");

   a_stall_means_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && s2_valid_ff && rsp_valid_ff && rsp_stall))
      else $error("input stalled while a stage is free");

   a_bad_word_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_word.bad_size) |->
         (rsp_word.luma == 8'd0 && !rsp_word.chroma_valid && !rsp_word.frame_last))
      else $error("bad-size word carries nonzero fields");

   a_chroma_on_odd: assert property (@(posedge clock) disable iff (reset)
      line_rd_en |=> s1_chroma_ff)
      else $error("line store read without a chroma word");

endmodule

@@ tb/tb_rgb_to_nv12_bt601_core.sv @@
// ----------------------------------------------------------------------------
// tb_rgb_to_nv12_bt601_core
// Self-checking bench for the RGB to NV12 converter. Pixels are sent in raster
// order under random idle and stall. Each accepted pixel is converted by a
// local model of luma, 2x2 chroma averaging, frame end and the size check.
// Every result word is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_rgb_to_nv12_bt601_core;
   import rgbnv12_pkg::*;

   localparam int CycleLimit   = 1000000;
   localparam int SettleCycles = 8;
   localparam int RandomTarget = 1000;
   localparam int MaxBurst     = 256;

   // Indexes past the two size registers; writes to them must be ignored.
   localparam logic [CsrIndexW-1:0] REG_SPARE_2 = 2'd2;
   localparam logic [CsrIndexW-1:0] REG_SPARE_3 = 2'd3;

   logic                 clock        = 1'b0;
   logic                 reset        = 1'b1;
   logic                 req_valid    = 1'b0;
   logic                 req_stall;
   req_word_type         req_word     = '0;
   logic                 rsp_valid;
   logic                 rsp_stall    = 1'b0;
   rsp_word_type         rsp_word;
   logic                 csr_write_en = 1'b0;
   logic [CsrIndexW-1:0] csr_index    = '0;
   logic [SizeW-1:0]     csr_wdata    = '0;

   req_word_type pending_pixels[$];
   rsp_word_type nv12_expected[$];

   // Local copy of the converter state and configuration.
   logic [SizeW-1:0] conv_width  = '0;
   logic [SizeW-1:0] conv_height = '0;
   int               conv_col    = 0;
   int               conv_row    = 0;
   req_word_type     conv_left   = '0;
   logic [26:0]      pair_line [LineDepth];

   int cycle_count     = 0;
   int mismatches      = 0;
   int pixels_accepted = 0;
   int words_checked   = 0;
   int chroma_blocks   = 0;
   int frame_ends      = 0;
   int bad_words       = 0;
   int csr_writes      = 0;
   int random_pixels   = 0;

   rgb_to_nv12_bt601_core dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_word     (req_word),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_word     (rsp_word),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // One window in every four, where bits 12:11 of cycle_count equal one, has no idling on either side.
   function automatic bit take_break();
      bit quiet;
      quiet = ((cycle_count >> 11) & 3) == 1;
      return !quiet && ($urandom_range(99) < 33);
   endfunction

   function automatic int clip_byte(input int v);
      if (v < 0) return 0;
      if (v > 255) return 255;
      return v;
   endfunction

   function automatic rsp_word_type convert_pixel(input req_word_type px);
      rsp_word_type res;
      int           sb, sg, sr, ab, ag, ar;
      logic [26:0]  above;
      bit           bad;
      res = '0;
      bad = (conv_width == 0) || (conv_height == 0) || conv_width[0] || conv_height[0]
            || (conv_width > MaxWidth) || (conv_height > MaxHeight);
      if (bad) begin
         res.bad_size = 1'b1;
         return res;
      end
      res.luma = 8'(((66 * int'(px.red) + 129 * int'(px.green) + 25 * int'(px.blue)
                      + 128) >> 8) + 16);
      if (conv_col[0] == 1'b0) begin
         conv_left = px;
      end else begin
         sb = int'(px.blue) + int'(conv_left.blue);
         sg = int'(px.green) + int'(conv_left.green);
         sr = int'(px.red) + int'(conv_left.red);
         if (conv_row[0] == 1'b0) begin
            pair_line[conv_col >> 1] = {9'(sr), 9'(sg), 9'(sb)};
         end else begin
            above = pair_line[conv_col >> 1];
            ab = (sb + int'(above[8:0])) >> 2;
            ag = (sg + int'(above[17:9])) >> 2;
            ar = (sr + int'(above[26:18])) >> 2;
            res.chroma_valid = 1'b1;
            res.chroma_blue  = 8'(clip_byte(((-38 * ar - 74 * ag + 112 * ab + 128) >>> 8)
                                            + 128));
            res.chroma_red   = 8'(clip_byte(((112 * ar - 94 * ag - 18 * ab + 128) >>> 8)
                                            + 128));
         end
      end
      res.frame_last = (conv_row + 1 == int'(conv_height)) && (conv_col + 1 == int'(conv_width));
      if (conv_col + 1 >= int'(conv_width)) begin
         conv_col = 0;
         conv_row = (conv_row + 1 >= int'(conv_height)) ? 0 : conv_row + 1;
      end else begin
         conv_col = conv_col + 1;
      end
      return res;
   endfunction

   // Pixel driver: predicts each accepted word and loads the next one.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            nv12_expected.push_back(convert_pixel(req_word));
            pixels_accepted++;
         end
         if (!req_valid || !req_stall) begin
            if (pending_pixels.size() != 0 && !take_break()) begin
               req_valid <= 1'b1;
               req_word  <= pending_pixels.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   task automatic check_field(input string field, input int want, input int got);
      if (want != got) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
   endtask

   // Result monitor: random back-pressure and in-order comparison.
   always @(posedge clock) begin
      rsp_word_type want;
      rsp_stall <= take_break();
      if (!reset && rsp_valid && !rsp_stall) begin
         if (nv12_expected.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected result word %h", $time, rsp_word);
         end else begin
            want = nv12_expected.pop_front();
            words_checked++;
            chroma_blocks += want.chroma_valid;
            frame_ends    += want.frame_last;
            bad_words     += want.bad_size;
            check_field("luma", want.luma, rsp_word.luma);
            check_field("chroma_valid", want.chroma_valid, rsp_word.chroma_valid);
            check_field("chroma_blue", want.chroma_blue, rsp_word.chroma_blue);
            check_field("chroma_red", want.chroma_red, rsp_word.chroma_red);
            check_field("frame_last", want.frame_last, rsp_word.frame_last);
            check_field("bad_size", want.bad_size, rsp_word.bad_size);
         end
      end
   end

   task automatic drain();
      while (pending_pixels.size() != 0 || req_valid || nv12_expected.size() != 0) begin
         @(posedge clock);
      end
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CsrIndexW-1:0] idx, input logic [SizeW-1:0] val);
      drain();
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= val;
      @(posedge clock);
      csr_write_en <= 1'b0;
      csr_writes++;
      if (idx == REG_FRAME_WIDTH) begin
         conv_width = val;
         conv_col   = 0;
         conv_row   = 0;
      end else if (idx == REG_FRAME_HEIGHT) begin
         conv_height = val;
         conv_col    = 0;
         conv_row    = 0;
      end
   endtask

   task automatic set_size(input int w, input int h);
      if ($urandom_range(1)) begin
         write_csr(REG_FRAME_WIDTH, SizeW'(w));
         write_csr(REG_FRAME_HEIGHT, SizeW'(h));
      end else begin
         write_csr(REG_FRAME_HEIGHT, SizeW'(h));
         write_csr(REG_FRAME_WIDTH, SizeW'(w));
      end
   endtask

   task automatic push_pixel(input logic [7:0] b, input logic [7:0] g, input logic [7:0] r);
      req_word_type px;
      px.blue  = b;
      px.green = g;
      px.red   = r;
      pending_pixels.push_back(px);
   endtask

   task automatic push_solid_block(input logic [7:0] b, input logic [7:0] g,
                                   input logic [7:0] r);
      repeat (4) push_pixel(b, g, r);
   endtask

   // Components lean toward the rails now and then.
   function automatic logic [7:0] rand_comp();
      if ($urandom_range(9) == 0) return $urandom_range(1) ? 8'hFF : 8'h00;
      return 8'($urandom);
   endfunction

   task automatic push_random(input int count);
      repeat (count) push_pixel(rand_comp(), rand_comp(), rand_comp());
   endtask

   // A size that is zero, odd or above the supported maximum.
   function automatic int bad_extent();
      case ($urandom_range(3))
         0: return 0;
         1: return 2 * $urandom_range(0, 2047) + 1;
         2: return MaxWidth + 2 + 2 * $urandom_range(0, 2046);
         default: return (1 << SizeW) - 1;
      endcase
   endfunction

   initial begin
      int w, h, n, split;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Out of reset both sizes are zero, so every word is flagged.
      push_random(2);
      set_size(2, 2);
      push_solid_block(8'hFF, 8'hFF, 8'hFF);
      push_solid_block(8'h00, 8'h00, 8'h00);
      push_solid_block(8'h00, 8'h00, 8'hFF);
      push_solid_block(8'hFF, 8'h00, 8'h00);
      write_csr(REG_FRAME_WIDTH, SizeW'(3));
      push_random(1);
      write_csr(REG_FRAME_WIDTH, SizeW'(MaxWidth + 2));
      push_random(1);
      write_csr(REG_FRAME_WIDTH, SizeW'(MaxWidth));
      write_csr(REG_FRAME_HEIGHT, SizeW'(5));
      push_random(1);

      while (random_pixels < RandomTarget) begin
         w = ($urandom_range(99) < 15) ? 2 * $urandom_range(1, 64) : 2 * $urandom_range(1, 8);
         h = ($urandom_range(99) < 15) ? 2 * $urandom_range(1, 16) : 2 * $urandom_range(1, 4);
         if ($urandom_range(99) < 12) begin
            case ($urandom_range(2))
               0: w = bad_extent();
               1: h = bad_extent();
               default: begin
                  w = bad_extent();
                  h = bad_extent();
               end
            endcase
            set_size(w, h);
            push_random(3);
         end else begin
            set_size(w, h);
            // Mostly whole frames; a partial frame is cut short by the next size write.
            n = ($urandom_range(99) < 75) ? w * h * $urandom_range(1, 2)
                                          : $urandom_range(1, 2 * w * h - 1);
            // Large frames are only started so that the run stays short.
            if (n > MaxBurst) begin
               n = MaxBurst;
            end
            if ($urandom_range(99) < 20) begin
               split = $urandom_range(1, n);
               push_random(split);
               write_csr($urandom_range(1) ? REG_SPARE_2 : REG_SPARE_3, SizeW'($urandom));
               push_random(n - split);
            end else begin
               push_random(n);
            end
            random_pixels += n;
         end
      end

      // Widest row and tallest frame, the first words of a frame each.
      set_size(MaxWidth, 2);
      push_random(64);
      set_size(2, MaxHeight);
      push_random(64);
      drain();

      $display("Checked %0d words from %0d pixels: %0d chroma blocks, %0d frame ends,",
               words_checked, pixels_accepted, chroma_blocks, frame_ends);
      $display("%0d bad-size words, over %0d register writes.", bad_words, csr_writes);
      if (mismatches == 0 && nv12_expected.size() == 0) begin
         $display("rgb_to_nv12_bt601_core regression: pass");
      end else begin
         $display("rgb_to_nv12_bt601_core regression: fail");
      end
      $finish;
   end

   initial begin
      wait (cycle_count >= CycleLimit);
      $display("Timeout after %0d cycles, %0d words still expected.", cycle_count,
               nv12_expected.size());
      $display("rgb_to_nv12_bt601_core regression: fail");
      $finish;
   end

endmodule

@@ files.f @@
rtl/rgbnv12_pkg.sv
rtl/rgbnv12_line_mem.sv
rtl/rgb_to_nv12_bt601_core.sv
tb/tb_rgb_to_nv12_bt601_core.sv
